// File: rtl/ilc_pkg.sv
// Shared types and constants for the inode location calculator.
// Holds the request, response, queue entry and configuration structs.
// No dependencies.
package ilc_pkg;

	localparam int DEF_MAX_GROUPS = 64;
	localparam int CFG_W          = 20;
	localparam int GRP_W          = 12;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [1:0] CFG_IPG = 2'd0;
	localparam logic [1:0] CFG_BSZ = 2'd1;
	localparam logic [1:0] CFG_ISZ = 2'd2;

	localparam logic OP_LOCATE = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [19:0] IPG_RST = 20'd2048;
	localparam logic [16:0] BSZ_RST = 17'd1024;
	localparam logic [10:0] ISZ_RST = 11'd128;
	localparam logic [16:0] IPB_RST = 17'(1024 / 128);

	typedef struct packed {
		logic        op;
		logic [31:0] inode_number;
		logic [5:0]  group_index;
		logic [31:0] table_start;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] block_number;
		logic [15:0] byte_offset;
	} out_t;

	typedef struct packed {
		logic             op;
		logic             zero;
		logic             oob;
		logic [GRP_W-1:0] group;
		logic [19:0]      index;
		logic [5:0]       group_index;
		logic [31:0]      table_start;
	} mid_t;

	typedef struct packed {
		logic [16:0] ipb;
		logic [10:0] isz;
	} cfg_t;

endpackage

// File: rtl/ilc_queue.sv
// Short request queue between the front and back halves.
// Register based, one read port at the head pointer.
// Depends on ilc_pkg.
module ilc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ilc_pkg::mid_t push_data,
	output logic          full,
	input  logic          pop,
	output ilc_pkg::mid_t pop_data,
	output logic          empty
);
	import ilc_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	mid_t            mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;

	assign full     = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !(push && !full) && (count_q != '0)) else $error("push into full queue");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not drain queue");

endmodule

// File: rtl/ilc_front.sv
// Front half: configuration registers, inodes-per-block unit and the
// pipelined group divider. Feeds classified requests into the queue.
// Depends on ilc_pkg.
module ilc_front #(
	parameter int MAX_GROUPS = ilc_pkg::DEF_MAX_GROUPS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [1:0]               cfg_index,
	input  logic [ilc_pkg::CFG_W-1:0] cfg_data,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  ilc_pkg::in_t             req,
	output logic                     push,
	output ilc_pkg::mid_t            push_data,
	input  logic                     q_full,
	output ilc_pkg::cfg_t            cfg
);
	import ilc_pkg::*;

	localparam int NS = 32;

	typedef struct packed {
		logic        op;
		logic        zero;
		logic [31:0] dvd;
		logic [19:0] rem;
		logic [31:0] quo;
		logic [5:0]  group_index;
		logic [31:0] table_start;
	} fst_t;

	typedef enum logic [1:0] {IPB_IDLE, IPB_LOAD, IPB_RUN} ipb_state_t;

	logic [19:0] ipg_q;
	logic [16:0] bsz_q;
	logic [10:0] isz_q;
	logic [16:0] ipb_q;
	ipb_state_t  ipb_state_q;
	logic [4:0]  ipb_cnt_q;
	logic [10:0] ipb_rem_q;
	logic [16:0] ipb_quo_q;
	logic [16:0] ipb_dvd_q;
	logic [10:0] isz_div;
	logic [11:0] ipb_t;
	logic        ipb_ge;
	logic [16:0] ipb_quo_nxt;
	logic [19:0] ipg_div;
	logic        busy;
	logic        en;
	fst_t        init;
	fst_t        fdiv_nxt [1:NS];
	fst_t        fdiv_s   [1:NS];
	logic        vld_s    [1:NS];

	function automatic fst_t fstep(fst_t a, logic [19:0] d);
		fst_t        r;
		logic [20:0] t;
		logic        ge;
		r     = a;
		t     = {a.rem, a.dvd[31]};
		ge    = (t >= {1'b0, d});
		r.rem = ge ? 20'(t - {1'b0, d}) : t[19:0];
		r.quo = {a.quo[30:0], ge};
		r.dvd = {a.dvd[30:0], 1'b0};
		return r;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipg_q <= IPG_RST;
			bsz_q <= BSZ_RST;
			isz_q <= ISZ_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IPG: ipg_q <= cfg_data[19:0];
				CFG_BSZ: bsz_q <= cfg_data[16:0];
				CFG_ISZ: isz_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Serial restoring divider: inodes per block = block size / inode size.
	assign isz_div     = (isz_q == '0) ? 11'd1 : isz_q;
	assign ipb_t       = {ipb_rem_q, ipb_dvd_q[16]};
	assign ipb_ge      = (ipb_t >= {1'b0, isz_div});
	assign ipb_quo_nxt = {ipb_quo_q[15:0], ipb_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipb_state_q <= IPB_IDLE;
			ipb_q       <= IPB_RST;
			ipb_cnt_q   <= '0;
			ipb_rem_q   <= '0;
			ipb_quo_q   <= '0;
			ipb_dvd_q   <= '0;
		end else if (cfg_write) begin
			ipb_state_q <= IPB_LOAD;
		end else begin
			case (ipb_state_q)
				IPB_LOAD: begin
					ipb_dvd_q   <= bsz_q;
					ipb_rem_q   <= '0;
					ipb_quo_q   <= '0;
					ipb_cnt_q   <= '0;
					ipb_state_q <= IPB_RUN;
				end
				IPB_RUN: begin
					ipb_rem_q <= ipb_ge ? 11'(ipb_t - {1'b0, isz_div}) : ipb_t[10:0];
					ipb_quo_q <= ipb_quo_nxt;
					ipb_dvd_q <= {ipb_dvd_q[15:0], 1'b0};
					ipb_cnt_q <= ipb_cnt_q + 1'b1;
					if (ipb_cnt_q == 5'd16) begin
						ipb_q       <= (ipb_quo_nxt == '0) ? 17'd1 : ipb_quo_nxt;
						ipb_state_q <= IPB_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	assign busy    = (ipb_state_q != IPB_IDLE) || cfg_write;
	assign cfg.ipb = ipb_q;
	assign cfg.isz = isz_q;

	// Group divider pipeline, one quotient bit per stage.
	assign ipg_div   = (ipg_q == '0) ? 20'd1 : ipg_q;
	assign en        = !(vld_s[NS] && q_full);
	assign req_stall = !en || busy;

	always_comb begin
		init.op          = req.op;
		init.zero        = (req.inode_number == '0);
		init.dvd         = req.inode_number - 32'd1;
		init.rem         = '0;
		init.quo         = '0;
		init.group_index = req.group_index;
		init.table_start = req.table_start;
		fdiv_nxt[1] = fstep(init, ipg_div);
		for (int k = 2; k <= NS; k++) begin
			fdiv_nxt[k] = fstep(fdiv_s[k-1], ipg_div);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= req_valid && !req_stall;
			for (int k = 2; k <= NS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fdiv_s <= fdiv_nxt;
		end
	end

	assign push = vld_s[NS] && !q_full;

	always_comb begin
		push_data.op          = fdiv_s[NS].op;
		push_data.zero        = fdiv_s[NS].zero;
		push_data.oob         = (fdiv_s[NS].quo >= 32'(MAX_GROUPS));
		push_data.group       = fdiv_s[NS].quo[GRP_W-1:0];
		push_data.index       = fdiv_s[NS].rem;
		push_data.group_index = fdiv_s[NS].group_index;
		push_data.table_start = fdiv_s[NS].table_start;
	end

	a_ipb_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ipb_q != '0) else $error("inodes per block is zero");
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NS] && !en) |=> vld_s[NS] && $stable(fdiv_s[NS]))
		else $error("stalled front output changed");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ipb_state_q == IPB_RUN) |-> !vld_s[1] || $past(en) == 1'b0 || $past(!busy))
		else $error("request accepted during divider update");

endmodule

// File: rtl/ilc_back.sv
// Back half: pipelined block divider, group table memory, offset
// multiply and the response register.
// Depends on ilc_pkg.
module ilc_back #(
	parameter int MAX_GROUPS = ilc_pkg::DEF_MAX_GROUPS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ilc_pkg::cfg_t cfg,
	input  logic          q_empty,
	input  ilc_pkg::mid_t q_data,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ilc_pkg::out_t rsp
);
	import ilc_pkg::*;

	localparam int NB = 20;
	localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

	typedef struct packed {
		logic             op;
		logic             zero;
		logic             oob;
		logic [GRP_W-1:0] group;
		logic [19:0]      dvd;
		logic [16:0]      rem;
		logic [19:0]      quo;
		logic [5:0]       group_index;
		logic [31:0]      table_start;
	} bst_t;

	bst_t        init;
	bst_t        bdiv_nxt [1:NB];
	bst_t        bdiv_s   [1:NB];
	logic        vld_s    [1:NB];
	logic        en;
	logic [31:0] tbl_q [MAX_GROUPS];
	logic        wr_en;
	logic [GW-1:0] wr_idx;
	logic [GW-1:0] rd_idx;
	logic        vld_sm;
	logic        op_sm;
	logic [1:0]  status_sm;
	logic [19:0] quo_sm;
	logic [15:0] off_sm;
	logic [31:0] rd_sm;
	logic        vld_so;
	out_t        rsp_so;

	function automatic bst_t bstep(bst_t a, logic [16:0] d);
		bst_t        r;
		logic [17:0] t;
		logic        ge;
		r     = a;
		t     = {a.rem, a.dvd[19]};
		ge    = (t >= {1'b0, d});
		r.rem = ge ? 17'(t - {1'b0, d}) : t[16:0];
		r.quo = {a.quo[18:0], ge};
		r.dvd = {a.dvd[18:0], 1'b0};
		return r;
	endfunction

	assign en  = !(vld_so && rsp_stall);
	assign pop = en && !q_empty;

	always_comb begin
		init.op          = q_data.op;
		init.zero        = q_data.zero;
		init.oob         = q_data.oob;
		init.group       = q_data.group;
		init.dvd         = q_data.index;
		init.rem         = '0;
		init.quo         = '0;
		init.group_index = q_data.group_index;
		init.table_start = q_data.table_start;
		bdiv_nxt[1] = bstep(init, cfg.ipb);
		for (int k = 2; k <= NB; k++) begin
			bdiv_nxt[k] = bstep(bdiv_s[k-1], cfg.ipb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NB; k++) begin
				vld_s[k] <= 1'b0;
			end
			vld_sm <= 1'b0;
			vld_so <= 1'b0;
		end else if (en) begin
			vld_s[1] <= pop;
			for (int k = 2; k <= NB; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			vld_sm <= vld_s[NB];
			vld_so <= vld_sm && (op_sm == OP_LOCATE);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bdiv_s <= bdiv_nxt;
		end
	end

	// Table access stage: table writes and lookups are applied here in request order.
	assign wr_idx = GW'(bdiv_s[NB].group_index);
	assign rd_idx = GW'(bdiv_s[NB].group);
	assign wr_en  = en && vld_s[NB] && (bdiv_s[NB].op == OP_WRITE)
		&& (32'(bdiv_s[NB].group_index) < 32'(MAX_GROUPS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_q[wr_idx] <= bdiv_s[NB].table_start;
		end
		if (en) begin
			rd_sm     <= tbl_q[rd_idx];
			op_sm     <= bdiv_s[NB].op;
			quo_sm    <= bdiv_s[NB].quo;
			off_sm    <= 16'(bdiv_s[NB].rem * cfg.isz);
			status_sm <= bdiv_s[NB].zero ? ST_ZERO :
				(bdiv_s[NB].oob ? ST_RANGE : ST_OK);
		end
	end

	// Response register.
	always_ff @(posedge clk) begin
		if (en) begin
			rsp_so.status       <= status_sm;
			rsp_so.block_number <= (status_sm == ST_OK) ? rd_sm + 32'(quo_sm) : '0;
			rsp_so.byte_offset  <= (status_sm == ST_OK) ? off_sm : '0;
		end
	end

	assign rsp_valid = vld_so;
	assign rsp       = rsp_so;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |-> (rsp.block_number == '0)
		&& (rsp.byte_offset == '0)) else $error("error response carries data");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_ZERO
		|| rsp.status == ST_RANGE)) else $error("bad status code");
	a_hold_access: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sm && !en) |=> vld_sm && $stable(quo_sm))
		else $error("stalled table stage changed");

endmodule

// File: rtl/inode_location_calculator.sv
// Top level of the ext2 inode location calculator.
// Instantiates ilc_front, ilc_queue and ilc_back; depends on ilc_pkg.
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid / req_stall  ilc_pkg::in_t
//  rsp       out        rsp_valid / rsp_stall  ilc_pkg::out_t
//  cfg       in         cfg_write              cfg_index, cfg_data
//
// One request enters per cycle while req_stall is low; a locate request
// passes through 32 group divider stages, the queue, 20 block divider
// stages, table access and the response register. Table writes give no
// response. After any configuration write the inodes-per-block divider
// runs again, and req_stall is high in the write cycle and until it ends.
// Reset is asynchronous and active low; the group table holds no reset
// value and a group must be written before it is looked up.
// A stalled response freezes the back half; the queue then absorbs the
// front half until it fills, after which req_stall rises.
module inode_location_calculator #(
	parameter int MAX_GROUPS = ilc_pkg::DEF_MAX_GROUPS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [1:0]                cfg_index,
	input  logic [ilc_pkg::CFG_W-1:0] cfg_data,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  ilc_pkg::in_t              req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output ilc_pkg::out_t             rsp
);
	import ilc_pkg::*;

	// Classified requests between the two halves.
	logic push;
	mid_t push_data;
	logic q_full;
	logic pop;
	mid_t pop_data;
	logic q_empty;
	// Derived configuration handed to the back half.
	cfg_t cfg;

	// The front half splits (inode - 1) into group and index.
	ilc_front #(
		.MAX_GROUPS(MAX_GROUPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full),
		.cfg       (cfg)
	);

	// The queue lets either half stall without freezing the other.
	ilc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// The back half finds the block and offset and applies table writes.
	ilc_back #(
		.MAX_GROUPS(MAX_GROUPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// File: verif/tb_inode_location_calculator.sv
// Self-checking testbench for the ext2 inode location calculator.
// Depends on ilc_pkg and inode_location_calculator; uses a small scoreboard
// class to predict and check responses.

class inode_loc_scoreboard;
	logic [19:0] ipg;
	logic [16:0] bsz;
	logic [10:0] isz;
	logic [31:0] table_start[64];
	ilc_pkg::out_t pending[$];
	int errors;
	int checked;

	function new();
		ipg = ilc_pkg::IPG_RST;
		bsz = ilc_pkg::BSZ_RST;
		isz = ilc_pkg::ISZ_RST;
		errors = 0;
		checked = 0;
		foreach (table_start[g]) table_start[g] = '0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [19:0] data);
		case (idx)
			ilc_pkg::CFG_IPG: ipg = data;
			ilc_pkg::CFG_BSZ: bsz = data[16:0];
			ilc_pkg::CFG_ISZ: isz = data[10:0];
			default: ;
		endcase
	endfunction

	// Works out the location for an accepted request, or records a table write.
	function void note(ilc_pkg::in_t r);
		logic [31:0] ipg_eff, pos, grp, idx, isz_div, ipb;
		logic [63:0] prod;
		ilc_pkg::out_t loc;
		if (r.op == ilc_pkg::OP_WRITE) begin
			table_start[r.group_index] = r.table_start;
			return;
		end
		loc = '0;
		if (r.inode_number == 0) begin
			loc.status = ilc_pkg::ST_ZERO;
		end else begin
			ipg_eff = (ipg == 0) ? 32'd1 : {12'd0, ipg};
			pos = r.inode_number - 32'd1;
			grp = pos / ipg_eff;
			idx = pos % ipg_eff;
			if (grp >= 64) begin
				loc.status = ilc_pkg::ST_RANGE;
			end else begin
				isz_div = (isz == 0) ? 32'd1 : {21'd0, isz};
				ipb = {15'd0, bsz} / isz_div;
				if (ipb == 0) ipb = 1;
				loc.status = ilc_pkg::ST_OK;
				loc.block_number = table_start[grp[5:0]] + idx / ipb;
				prod = 64'(idx % ipb) * 64'(isz);
				loc.byte_offset = prod[15:0];
			end
		end
		pending.push_back(loc);
	endfunction

	function void check(ilc_pkg::out_t got);
		ilc_pkg::out_t exp_loc;
		if (pending.size() == 0) begin
			$error("response with no request waiting: %p", got);
			errors++;
			return;
		end
		exp_loc = pending.pop_front();
		checked++;
		if (got.status !== exp_loc.status) begin
			$error("status: expected %0d, got %0d", exp_loc.status, got.status);
			errors++;
		end
		if (got.block_number !== exp_loc.block_number) begin
			$error("block_number: expected %0h, got %0h",
				exp_loc.block_number, got.block_number);
			errors++;
		end
		if (got.byte_offset !== exp_loc.byte_offset) begin
			$error("byte_offset: expected %0h, got %0h",
				exp_loc.byte_offset, got.byte_offset);
			errors++;
		end
	endfunction
endclass

module tb_inode_location_calculator;
	import ilc_pkg::*;

	// Index 3 names no register; writing it must change nothing.
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	// Covers the response latency, with some margin, when draining.
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int ITEMS_PER_PHASE = 140;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	in_t         req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	out_t        rsp;

	inode_location_calculator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	inode_loc_scoreboard sb = new();

	// Groups whose table start has been written; locates only target these.
	bit written[64];
	int accepted = 0;
	int settings = 0;
	int snd_idle = 22;
	int rcv_idle = 88;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int cycles = 0;

	always #1 clk = ~clk;

	// Watchdog: a hung block must not run forever.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here so that
	// the queue fills and the block pushes back on its request side.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (!hold_done && accepted >= 450) begin
			hold_left <= 300;
			hold_done <= 1'b1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < rcv_idle);
		end
	end

	// Responses are sampled at the rising edge, where the handshake happens.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check(rsp);
	end

	// Offers one request and holds it until the block takes it. Called and
	// returns at a falling edge.
	task automatic send_request(in_t r);
		if ($urandom_range(0, 99) < snd_idle) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		sb.note(r);
		accepted++;
		if (r.op == OP_WRITE) written[r.group_index] = 1'b1;
		@(negedge clk);
	endtask

	// Waits until every expected response is back, then lets the pipeline
	// settle, since table writes leave no response to wait for.
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after the last write.
	task automatic write_reg(logic [1:0] idx, logic [19:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic apply_setting(logic [19:0] ipg, logic [19:0] bsz, logic [19:0] isz);
		drain();
		write_reg(CFG_IPG, ipg);
		write_reg(CFG_BSZ, bsz);
		write_reg(CFG_ISZ, isz);
		cfg_write <= 1'b0;
		settings++;
	endtask

	function automatic in_t write_item(logic [5:0] g, logic [31:0] start);
		in_t r;
		r.op = OP_WRITE;
		r.inode_number = $urandom();
		r.group_index = g;
		r.table_start = start;
		return r;
	endfunction

	function automatic in_t locate_item(logic [31:0] n);
		in_t r;
		r.op = OP_LOCATE;
		r.inode_number = n;
		r.group_index = 6'($urandom());
		r.table_start = $urandom();
		return r;
	endfunction

	// Builds a locate inside a written group, with the index biased toward
	// both ends of the group.
	function automatic in_t well_formed_locate();
		logic [31:0] ipg_eff, idx;
		int g;
		ipg_eff = (sb.ipg == 0) ? 32'd1 : {12'd0, sb.ipg};
		do g = $urandom_range(0, 63); while (!written[g]);
		case ($urandom_range(0, 5))
			0: idx = 0;
			1: idx = ipg_eff - 1;
			default: idx = $urandom() % ipg_eff;
		endcase
		return locate_item(32'(g) * ipg_eff + idx + 32'd1);
	endfunction

	// A locate is legal unless it lands in a group never written.
	function automatic bit lands_unwritten(logic [31:0] n);
		logic [31:0] ipg_eff, grp;
		if (n == 0) return 1'b0;
		ipg_eff = (sb.ipg == 0) ? 32'd1 : {12'd0, sb.ipg};
		grp = (n - 32'd1) / ipg_eff;
		return (grp < 64) && !written[grp[5:0]];
	endfunction

	task automatic random_phase(int count);
		in_t r;
		logic [31:0] n;
		for (int i = 0; i < count; i++) begin
			// The idle pattern moves on with the overall request count.
			if (accepted < 420) begin
				snd_idle = 22; rcv_idle = 88;
			end else if (accepted < 800) begin
				snd_idle = 88; rcv_idle = 22;
			end else begin
				snd_idle = 0; rcv_idle = 0;
			end
			case ($urandom_range(0, 9))
				0, 1: r = write_item(6'($urandom()), $urandom());
				2: begin
					// Noise: zero, the top value, or anything legal.
					case ($urandom_range(0, 2))
						0: n = 0;
						1: n = 32'hFFFF_FFFF;
						default: n = $urandom();
					endcase
					if (lands_unwritten(n)) n = 0;
					r = locate_item(n);
				end
				default: r = well_formed_locate();
			endcase
			send_request(r);
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part under the reset settings (2048 per group, 8 per block).
		send_request(write_item(6'd0, 32'd0));
		send_request(write_item(6'd63, 32'hFFFF_FFFF));
		send_request(write_item(6'd1, 32'h8000_0000));
		send_request(write_item(6'd42, 32'h1234_5678));
		send_request(locate_item(32'd0));
		send_request(locate_item(32'd1));
		send_request(locate_item(32'd8));
		send_request(locate_item(32'd9));
		send_request(locate_item(32'd2048));
		send_request(locate_item(32'd2049));
		// Top of the last group: the block number wraps past 2^32.
		send_request(locate_item(32'd131072));
		send_request(locate_item(32'd129025));
		// First inode past the table.
		send_request(locate_item(32'd131073));
		send_request(locate_item(32'hFFFF_FFFF));
		send_request(locate_item(32'd86017));
		// Writing the unused index must leave the settings alone.
		drain();
		write_reg(CFG_UNUSED, 20'hFFFFF);
		cfg_write <= 1'b0;
		send_request(locate_item(32'd2055));
		// Rewriting a group replaces its table start.
		send_request(write_item(6'd1, 32'd77));
		send_request(locate_item(32'd2050));

		// Each setting gets its own stretch of random requests.
		random_phase(ITEMS_PER_PHASE);
		apply_setting(20'd1, 20'd65536, 20'd1024);
		random_phase(ITEMS_PER_PHASE);
		apply_setting(20'd524288, 20'd1024, 20'd128);
		random_phase(ITEMS_PER_PHASE);
		// Degenerate divisors: zero inodes per group and zero inode size.
		apply_setting(20'd0, 20'd4096, 20'd0);
		random_phase(ITEMS_PER_PHASE);
		// Block smaller than one inode gives one inode per block.
		apply_setting(20'd37, 20'd100, 20'd1024);
		random_phase(ITEMS_PER_PHASE);
		// Largest raw values, so the offset overflows 16 bits; upper data bits
		// beyond each register's width are set as well.
		apply_setting(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		random_phase(ITEMS_PER_PHASE);
		apply_setting(20'($urandom_range(1, 5000)), 20'($urandom_range(1024, 65536)),
			20'($urandom_range(128, 1024)));
		random_phase(ITEMS_PER_PHASE);
		apply_setting(20'($urandom()), 20'($urandom()), 20'($urandom()));
		random_phase(ITEMS_PER_PHASE);

		drain();
		$display("covered %0d requests and %0d checked responses over %0d settings,",
			accepted, sb.checked, settings + 1);
		$display("including a long response hold-off and both idle patterns");
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/ilc_pkg.sv
rtl/ilc_queue.sv
rtl/ilc_front.sv
rtl/ilc_back.sv
rtl/inode_location_calculator.sv
verif/tb_inode_location_calculator.sv
